// ===== sv/llfp_pkg.sv =====
`timescale 1ns / 1ps

package llfp_pkg;

    // one-hot parser states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_HEADER = 7'b0000010,
        ST_FILEID = 7'b0000100,
        ST_DELIM  = 7'b0001000,
        ST_BODY   = 7'b0010000,
        ST_ENDL   = 7'b0100000,
        ST_FAIL   = 7'b1000000
    } parse_state_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_OPEN      = 3'd1,
        ACT_BODY      = 3'd2,
        ACT_CLOSE_OK  = 3'd3,
        ACT_CLOSE_ERR = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        RSN_NONE     = 2'd0,
        RSN_NO_DELIM = 2'd1,
        RSN_RANGE    = 2'd2,
        RSN_TOO_LONG = 2'd3
    } fail_reason_t;

    localparam logic [2:0] REG_HEADER_BYTE   = 3'd0;
    localparam logic [2:0] REG_START_BYTE    = 3'd1;
    localparam logic [2:0] REG_END_BYTE      = 3'd2;
    localparam logic [2:0] REG_BODY_MIN      = 3'd3;
    localparam logic [2:0] REG_BODY_MAX      = 3'd4;
    localparam logic [2:0] REG_MAX_ROW_BYTES = 3'd5;
    localparam logic [2:0] REG_START_FILE    = 3'd6;

    localparam logic [7:0]  RST_HEADER_BYTE   = 8'd255;
    localparam logic [7:0]  RST_START_BYTE    = 8'd2;
    localparam logic [7:0]  RST_END_BYTE      = 8'd10;
    localparam logic [7:0]  RST_BODY_MIN      = 8'd32;
    localparam logic [7:0]  RST_BODY_MAX      = 8'd126;
    localparam logic [7:0]  RST_MAX_ROW_BYTES = 8'd64;
    localparam logic [15:0] RST_START_FILE    = 16'd1;

    localparam logic [8:0] ROW_COUNT_MAX = 9'd511;

    typedef struct packed {
        logic [7:0]  header_byte;
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [7:0]  body_min;
        logic [7:0]  body_max;
        logic [7:0]  max_row_bytes;
        logic [15:0] start_file_num;
    } cfg_t;

    typedef struct packed {
        action_t      action;
        logic [15:0]  file_num;
        logic         new_file;
        logic [7:0]   out_byte;
        fail_reason_t fail_reason;
    } result_t;

endpackage

// ===== sv/log_line_frame_parser_top.sv =====
`timescale 1ns / 1ps

// log line frame parser
// s_ channel: one received byte per request; frames are header bytes, a file
// id byte, a start delimiter, body bytes and an end byte.
// m_ channel: exactly one action per input byte (open line, body byte,
// close ok, close on failure, or none) with file number and fail reason.
// apb port: seven framing registers at byte addresses 0, 4, .. 24.
// the result of a byte is registered and is on m_ in the cycle after it is accepted.
// throughput: one byte per cycle unless m_tready stalls; the parse state
// update and output register form a single stage, so the state loop sets it.
// the output register is refilled in the cycle it is drained, so a new byte
// is taken while the previous result is being handed off.
// when the receiver stalls, s_tready drops as soon as the output register
// holds an untaken result, and resumes once m_tready returns.
// reset (aresetn low, synchronous) returns the parser to idle, clears the
// row count, last file id and file offset, loads register defaults and
// empties the output register.
module log_line_frame_parser_top import llfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] file number, [16] new_file,
                                   // [24:17] out_byte, [26:25] fail_reason
    output logic [2:0]  m_tuser,   // [2:0] action
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg;
    result_t res;

    llfp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    llfp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tuser = res.action;
    assign m_tdata = {5'd0, res.fail_reason, res.out_byte, res.new_file, res.file_num};

endmodule

// ===== sv/llfp_cfg.sv =====
`timescale 1ns / 1ps

module llfp_cfg import llfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_byte    <= RST_HEADER_BYTE;
            cfg_reg.start_byte     <= RST_START_BYTE;
            cfg_reg.end_byte       <= RST_END_BYTE;
            cfg_reg.body_min       <= RST_BODY_MIN;
            cfg_reg.body_max       <= RST_BODY_MAX;
            cfg_reg.max_row_bytes  <= RST_MAX_ROW_BYTES;
            cfg_reg.start_file_num <= RST_START_FILE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HEADER_BYTE:   cfg_reg.header_byte    <= pwdata[7:0];
                REG_START_BYTE:    cfg_reg.start_byte     <= pwdata[7:0];
                REG_END_BYTE:      cfg_reg.end_byte       <= pwdata[7:0];
                REG_BODY_MIN:      cfg_reg.body_min       <= pwdata[7:0];
                REG_BODY_MAX:      cfg_reg.body_max       <= pwdata[7:0];
                REG_MAX_ROW_BYTES: cfg_reg.max_row_bytes  <= pwdata[7:0];
                REG_START_FILE:    cfg_reg.start_file_num <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HEADER_BYTE:   prdata = {24'd0, cfg_reg.header_byte};
            REG_START_BYTE:    prdata = {24'd0, cfg_reg.start_byte};
            REG_END_BYTE:      prdata = {24'd0, cfg_reg.end_byte};
            REG_BODY_MIN:      prdata = {24'd0, cfg_reg.body_min};
            REG_BODY_MAX:      prdata = {24'd0, cfg_reg.body_max};
            REG_MAX_ROW_BYTES: prdata = {24'd0, cfg_reg.max_row_bytes};
            REG_START_FILE:    prdata = {16'd0, cfg_reg.start_file_num};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ===== sv/llfp_core.sv =====
`timescale 1ns / 1ps

module llfp_core import llfp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res
);

    parse_state_t state_reg, state_next;
    logic [8:0]   row_count_reg, row_count_next;
    logic [7:0]   last_id_reg, last_id_next;
    logic [15:0]  offset_reg, offset_next;
    logic         res_valid_reg;
    result_t      res_reg, res_next;
    logic         accept;
    logic [8:0]   row_inc;
    logic         is_hdr;

    // result register frees up in the same cycle it is taken
    assign in_ready  = !res_valid_reg || res_ready;
    assign accept    = in_valid && in_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign is_hdr  = (in_byte == cfg.header_byte);
    assign row_inc = (row_count_reg < ROW_COUNT_MAX) ? row_count_reg + 9'd1 : row_count_reg;

    always_comb begin
        state_next     = state_reg;
        row_count_next = row_count_reg;
        last_id_next   = last_id_reg;
        offset_next    = offset_reg;
        res_next       = '0;

        case (state_reg)
            ST_IDLE:   state_next = is_hdr ? ST_HEADER : ST_IDLE;
            ST_HEADER: state_next = is_hdr ? ST_HEADER : ST_FILEID;
            ST_FILEID: begin
                if (in_byte == cfg.start_byte) begin
                    state_next = ST_DELIM;
                end else begin
                    state_next           = ST_FAIL;
                    res_next.fail_reason = RSN_NO_DELIM;
                end
            end
            // first byte after the delimiter passes unchecked
            ST_DELIM: begin
                row_count_next = '0;
                state_next     = ST_BODY;
            end
            ST_BODY: begin
                if (in_byte == cfg.end_byte) begin
                    state_next = ST_ENDL;
                end else if (in_byte < cfg.body_min || in_byte > cfg.body_max) begin
                    state_next           = ST_FAIL;
                    res_next.fail_reason = RSN_RANGE;
                end else begin
                    row_count_next = row_inc;
                    if (row_inc > {1'b0, cfg.max_row_bytes}) begin
                        state_next           = ST_FAIL;
                        res_next.fail_reason = RSN_TOO_LONG;
                    end else begin
                        state_next = ST_BODY;
                    end
                end
            end
            default: state_next = is_hdr ? ST_HEADER : ST_IDLE;
        endcase

        case (state_next)
            ST_FILEID: begin
                if (in_byte != last_id_reg) begin
                    offset_next       = offset_reg + 16'd1;
                    last_id_next      = in_byte;
                    res_next.new_file = 1'b1;
                end
                res_next.action   = ACT_OPEN;
                res_next.file_num = cfg.start_file_num + offset_next;
            end
            ST_BODY: begin
                res_next.action   = ACT_BODY;
                res_next.out_byte = in_byte;
            end
            ST_ENDL: res_next.action = ACT_CLOSE_OK;
            ST_FAIL: res_next.action = ACT_CLOSE_ERR;
            default: res_next.action = ACT_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_count_reg <= '0;
            last_id_reg   <= '0;
            offset_reg    <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg     <= state_next;
                row_count_reg <= row_count_next;
                last_id_reg   <= last_id_next;
                offset_reg    <= offset_next;
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import llfp_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd7;

    localparam int ITEMS_PER_PHASE = 250;
    localparam int N_PHASES        = 7;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 5000;
    localparam int ROW_LIMIT_AT    = 22;
    localparam int MAX_REPORTS     = 40;

    localparam result_t UNTYPED = '0;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state and register copy
    cfg_t         mcfg;
    parse_state_t mstate;
    logic [8:0]   mrow;
    logic [7:0]   mlast_id;
    logic [15:0]  moffset;

    result_t   pending_actions[$];
    stim_row_t stim_tab[$];

    int errors = 0;
    int n_sent = 0;
    int n_open = 0;
    int n_ok   = 0;
    int n_fail = 0;
    int src_idle;
    int sink_idle;
    int hold_seq = 0;

    log_line_frame_parser_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic result_t mk(action_t a, logic [15:0] f, logic n, logic [7:0] o,
                                   fail_reason_t r);
        result_t x;
        x.action      = a;
        x.file_num    = f;
        x.new_file    = n;
        x.out_byte    = o;
        x.fail_reason = r;
        return x;
    endfunction

    // framing state machine: one action per received byte
    function automatic result_t next_action(logic [7:0] b);
        parse_state_t nxt;
        result_t      r;
        r = mk(ACT_NONE, 16'd0, 1'b0, 8'd0, RSN_NONE);
        case (mstate)
            ST_IDLE: nxt = (b == mcfg.header_byte) ? ST_HEADER : ST_IDLE;
            ST_HEADER: nxt = (b != mcfg.header_byte) ? ST_FILEID : ST_HEADER;
            ST_FILEID: begin
                if (b == mcfg.start_byte) begin
                    nxt = ST_DELIM;
                end else begin
                    nxt = ST_FAIL;
                    r.fail_reason = RSN_NO_DELIM;
                end
            end
            ST_DELIM: begin
                // first byte after the delimiter goes through unchecked
                mrow = '0;
                nxt  = ST_BODY;
            end
            ST_BODY: begin
                if (b == mcfg.end_byte) begin
                    nxt = ST_ENDL;
                end else if (b < mcfg.body_min || b > mcfg.body_max) begin
                    nxt = ST_FAIL;
                    r.fail_reason = RSN_RANGE;
                end else begin
                    if (mrow < ROW_COUNT_MAX) mrow = mrow + 9'd1;
                    if (mrow > {1'b0, mcfg.max_row_bytes}) begin
                        nxt = ST_FAIL;
                        r.fail_reason = RSN_TOO_LONG;
                    end else begin
                        nxt = ST_BODY;
                    end
                end
            end
            default: nxt = (b == mcfg.header_byte) ? ST_HEADER : ST_IDLE;
        endcase
        mstate = nxt;
        case (nxt)
            ST_FILEID: begin
                if (b != mlast_id) begin
                    moffset    = moffset + 16'd1;
                    mlast_id   = b;
                    r.new_file = 1'b1;
                end
                r.action   = ACT_OPEN;
                r.file_num = mcfg.start_file_num + moffset;
            end
            ST_BODY: begin
                r.action   = ACT_BODY;
                r.out_byte = b;
            end
            ST_ENDL: r.action = ACT_CLOSE_OK;
            ST_FAIL: r.action = ACT_CLOSE_ERR;
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [7:0] b, input bit typed, input result_t want);
        stim_row_t row;
        row.b     = b;
        row.typed = typed;
        row.want  = want;
        stim_tab.push_back(row);
    endtask

    // offer one byte, wait for the request to be taken, then log what it should produce
    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
        result_t pred;
        while (int'($urandom_range(0, 99)) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        pred = next_action(b);
        pending_actions.push_back(typed ? want : pred);
        n_sent++;
    endtask

    task automatic send_frame();
        int         len;
        int         lim;
        int         i;
        logic [7:0] id;
        logic [7:0] b;
        repeat ($urandom_range(1, 3)) send_byte(mcfg.header_byte, 1'b0, UNTYPED);
        case ($urandom_range(0, 3))
            0: id = mlast_id;
            1: id = 8'($urandom);
            default: id = 8'($urandom_range(0, 3));
        endcase
        if (id == mcfg.header_byte) id = ~id;
        send_byte(id, 1'b0, UNTYPED);
        send_byte(($urandom_range(0, 15) == 0) ? 8'($urandom) : mcfg.start_byte,
                  1'b0, UNTYPED);
        send_byte(8'($urandom), 1'b0, UNTYPED);
        lim = int'(mcfg.max_row_bytes);
        if ($urandom_range(0, 9) == 0) begin
            // lines just under, at and just over the row limit
            len = lim + int'($urandom_range(0, 2)) - 1;
            if (len < 0) len = 0;
        end else begin
            len = int'($urandom_range(0, (lim < 20) ? lim : 20));
        end
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 39) == 0) begin
                b = 8'($urandom);
            end else begin
                b = 8'($urandom_range(mcfg.body_min, mcfg.body_max));
                repeat (4) begin
                    if (b == mcfg.end_byte) b = 8'($urandom_range(mcfg.body_min, mcfg.body_max));
                end
            end
            send_byte(b, 1'b0, UNTYPED);
        end
        if ($urandom_range(0, 19) != 0) send_byte(mcfg.end_byte, 1'b0, UNTYPED);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        logic [31:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (idx == REG_START_FILE) ? {junk[31:16], val} : {junk[31:8], val[7:0]};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_HEADER_BYTE:   mcfg.header_byte    = val[7:0];
            REG_START_BYTE:    mcfg.start_byte     = val[7:0];
            REG_END_BYTE:      mcfg.end_byte       = val[7:0];
            REG_BODY_MIN:      mcfg.body_min       = val[7:0];
            REG_BODY_MAX:      mcfg.body_max       = val[7:0];
            REG_MAX_ROW_BYTES: mcfg.max_row_bytes  = val[7:0];
            REG_START_FILE:    mcfg.start_file_num = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic cmp_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    task automatic check_result();
        result_t want;
        if (pending_actions.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: unexpected result, expected none, actual action %0h data %0h",
                         $time, m_tuser, m_tdata);
        end else begin
            want = pending_actions.pop_front();
            cmp_field("action", int'(want.action), int'(m_tuser));
            cmp_field("file num", int'(want.file_num), int'(m_tdata[15:0]));
            cmp_field("new_file", int'(want.new_file), int'(m_tdata[16]));
            cmp_field("out_byte", int'(want.out_byte), int'(m_tdata[24:17]));
            cmp_field("fail_reason", int'(want.fail_reason), int'(m_tdata[26:25]));
            case (want.action)
                ACT_OPEN:      n_open++;
                ACT_CLOSE_OK:  n_ok++;
                ACT_CLOSE_ERR: n_fail++;
                default: ;
            endcase
        end
    endtask

    // result side: check, then pick the next ready
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) check_result();
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (int'($urandom_range(0, 99)) >= sink_idle);
            end
        end
    end

    initial begin
        int idle_cnt;
        idle_cnt = 0;
        while (idle_cnt < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cnt = 0;
            else idle_cnt++;
        end
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int   i;
        int   ph;
        int   start_n;
        cfg_t c;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 5'd0;
        pwdata   <= 32'd0;
        mcfg = '{RST_HEADER_BYTE, RST_START_BYTE, RST_END_BYTE, RST_BODY_MIN, RST_BODY_MAX,
                 RST_MAX_ROW_BYTES, RST_START_FILE};
        mstate   = ST_IDLE;
        mrow     = '0;
        mlast_id = '0;
        moffset  = '0;
        src_idle  = 35;
        sink_idle = 83;

        // directed frames under the reset settings, but for the last one
        add_row(8'h00, 1'b1, mk(ACT_NONE, 16'd0, 1'b0, 8'h00, RSN_NONE));
        add_row(8'hFF, 1'b1, mk(ACT_NONE, 16'd0, 1'b0, 8'h00, RSN_NONE));
        add_row(8'h07, 1'b1, mk(ACT_OPEN, 16'd2, 1'b1, 8'h00, RSN_NONE));
        add_row(8'h02, 1'b1, mk(ACT_NONE, 16'd0, 1'b0, 8'h00, RSN_NONE));
        // end byte right after the delimiter is body data
        add_row(8'h0A, 1'b1, mk(ACT_BODY, 16'd0, 1'b0, 8'h0A, RSN_NONE));
        add_row(8'h20, 1'b0, UNTYPED);
        add_row(8'h7E, 1'b0, UNTYPED);
        add_row(8'h0A, 1'b1, mk(ACT_CLOSE_OK, 16'd0, 1'b0, 8'h00, RSN_NONE));
        add_row(8'hFF, 1'b1, mk(ACT_NONE, 16'd0, 1'b0, 8'h00, RSN_NONE));
        // same file id again: no file change
        add_row(8'h07, 1'b1, mk(ACT_OPEN, 16'd2, 1'b0, 8'h00, RSN_NONE));
        add_row(8'h33, 1'b1, mk(ACT_CLOSE_ERR, 16'd0, 1'b0, 8'h00, RSN_NO_DELIM));
        add_row(8'hFF, 1'b1, mk(ACT_NONE, 16'd0, 1'b0, 8'h00, RSN_NONE));
        add_row(8'h00, 1'b1, mk(ACT_OPEN, 16'd3, 1'b1, 8'h00, RSN_NONE));
        add_row(8'h02, 1'b1, mk(ACT_NONE, 16'd0, 1'b0, 8'h00, RSN_NONE));
        add_row(8'h00, 1'b1, mk(ACT_BODY, 16'd0, 1'b0, 8'h00, RSN_NONE));
        add_row(8'h1F, 1'b1, mk(ACT_CLOSE_ERR, 16'd0, 1'b0, 8'h00, RSN_RANGE));
        add_row(8'h41, 1'b1, mk(ACT_NONE, 16'd0, 1'b0, 8'h00, RSN_NONE));
        add_row(8'hFF, 1'b1, mk(ACT_NONE, 16'd0, 1'b0, 8'h00, RSN_NONE));
        add_row(8'h80, 1'b1, mk(ACT_OPEN, 16'd4, 1'b1, 8'h00, RSN_NONE));
        add_row(8'h02, 1'b1, mk(ACT_NONE, 16'd0, 1'b0, 8'h00, RSN_NONE));
        add_row(8'h7F, 1'b1, mk(ACT_BODY, 16'd0, 1'b0, 8'h7F, RSN_NONE));
        add_row(8'h7F, 1'b1, mk(ACT_CLOSE_ERR, 16'd0, 1'b0, 8'h00, RSN_RANGE));
        // with a row limit of zero the first checked byte fails
        add_row(8'hFF, 1'b1, mk(ACT_NONE, 16'd0, 1'b0, 8'h00, RSN_NONE));
        add_row(8'h05, 1'b0, UNTYPED);
        add_row(8'h02, 1'b1, mk(ACT_NONE, 16'd0, 1'b0, 8'h00, RSN_NONE));
        add_row(8'h41, 1'b1, mk(ACT_BODY, 16'd0, 1'b0, 8'h41, RSN_NONE));
        add_row(8'h41, 1'b1, mk(ACT_CLOSE_ERR, 16'd0, 1'b0, 8'h00, RSN_TOO_LONG));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < stim_tab.size(); i++) begin
            if (i == ROW_LIMIT_AT) begin
                drain();
                write_reg(REG_MAX_ROW_BYTES, 16'd0);
            end
            send_byte(stim_tab[i].b, stim_tab[i].typed, stim_tab[i].want);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            drain();
            case (ph)
                0: c = '{8'hFF, 8'h02, 8'h0A, 8'h20, 8'h7E, 8'd8, 16'hFFFE};
                1: c = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'd255, 16'h0000};
                2: c = '{8'($urandom), 8'($urandom), 8'($urandom), 8'h30, 8'h39, 8'd1,
                         16'($urandom)};
                // inverted range: every checked byte but the end byte fails
                3: c = '{8'($urandom), 8'($urandom), 8'($urandom), 8'h80, 8'h40, 8'd16,
                         16'($urandom)};
                5: c = '{8'hAA, 8'h55, 8'h0D, 8'h20, 8'h7E, 8'd40, 16'hFFFF};
                default: c = '{8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom_range(0, 64)), 8'($urandom_range(96, 255)),
                               8'($urandom_range(1, 60)), 16'($urandom)};
            endcase
            write_reg(REG_HEADER_BYTE, {8'd0, c.header_byte});
            write_reg(REG_START_BYTE, {8'd0, c.start_byte});
            write_reg(REG_END_BYTE, {8'd0, c.end_byte});
            write_reg(REG_BODY_MIN, {8'd0, c.body_min});
            write_reg(REG_BODY_MAX, {8'd0, c.body_max});
            write_reg(REG_MAX_ROW_BYTES, {8'd0, c.max_row_bytes});
            write_reg(REG_START_FILE, c.start_file_num);
            // unmapped address must leave the settings alone
            if (ph == 0) write_reg(REG_SPARE, 16'($urandom));

            if (ph < 2) begin
                src_idle  = 35;
                sink_idle = 83;
            end else if (ph < 4) begin
                src_idle  = 83;
                sink_idle = 35;
            end else begin
                src_idle  = 0;
                sink_idle = 0;
            end
            // long receiver hold while bytes keep coming
            if (ph == 5) hold_seq++;

            start_n = n_sent;
            while (n_sent - start_n < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, UNTYPED);
                end else begin
                    send_frame();
                end
            end
        end

        drain();
        $display("summary: %0d bytes, %0d settings, %0d opened, %0d ok, %0d failed",
                 n_sent, N_PHASES + 2, n_open, n_ok, n_fail);
        $display("summary: both sides idled in turn, one %0d-cycle receiver hold", HOLD_CYCLES);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
